@@ rtl/pbo_pkg.sv @@
// Shared types and constants of the point box obstacle check block.
package pbo_pkg;

  localparam int CAPACITY_DEF    = 512;
  localparam int COORD_WIDTH_DEF = 16;

  localparam int ACTION_W    = 2;
  localparam int VOXEL_W     = 12;
  localparam int VOXEL_RST   = 100;
  localparam int COUNT_OUT_W = 10;
  localparam int OUT_W       = 16;

  // Grid rounding: floor((v + ROUND_HALF) / ROUND_STEP) * ROUND_STEP
  localparam int ROUND_HALF = 50;
  localparam int ROUND_STEP = 100;

  // Division by 100 as a shift by 2 and a reciprocal multiplication by 1/25:
  // floor(m / 25) = (m * RECIP_25) >> RECIP_SH for every m below 2^30
  localparam int RECIP_25  = 1374389535;
  localparam int RECIP_W   = 31;
  localparam int RECIP_SH  = 35;
  localparam int DIV_STEPS = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIV    = 5'b00010,
    ST_ROUND  = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

  typedef struct packed {
    logic accept;     // take a new item: latch coordinates, clear flags
    logic insert;     // append the item's point, or flag it dropped
    logic clear;      // empty the store
    logic div_step;   // advance the rounding division by one stage
    logic round;      // register the rounded query point, rewind the scan
    logic scan_step;  // read the next entry and test the previous one
    logic out_load;   // move the finished result into the output register
  } cmd_t;

  typedef struct packed {
    logic div_last;   // the current division step is the final one
    logic scan_done;  // every stored entry has been tested
  } sts_t;

endpackage

@@ rtl/point_box_obstacle_check.sv @@
// Top level of the point box obstacle check block.
//
// Keeps up to CAPACITY obstacle points and answers box collision queries.
// Each input item carries an action (insert, query, clear) and a point in
// signed millimetres; each item gives exactly one result item with hit,
// dropped and the number of points held afterwards (low 10 bits). A query
// rounds its point to the nearest 100 mm, then tests every stored point for
// 2*|d| <= voxel_size_mm on all three axes. Items are handled one at a time,
// and the next item is accepted in the cycle after the one that loads the
// output register. Insert, clear and the unused action code go from the
// accepting cycle to that load. A query passes the accepting cycle, a
// rounding step (a reciprocal multiplication by 1/25 after a shift by two)
// and a step of floor correction, both in all three axes at once, a step
// that registers the rounded point, a scan of the stored points through the
// store's single read port, and the load of the output register. The output
// register decouples the sides, so the next item is accepted while a result
// waits on the master side; a new result is held back only until that one
// is taken. The store needs no clearing pass: only entries below the point
// count are ever read. voxel_size_mm resets to 100 and is written through
// cfg_we_i / cfg_wdata_i; the user must write it only while idle, which the
// block itself does not enforce.
module point_box_obstacle_check #(
  parameter int CAPACITY    = pbo_pkg::CAPACITY_DEF,
  parameter int COORD_WIDTH = pbo_pkg::COORD_WIDTH_DEF,
  localparam int IN_W = ((pbo_pkg::ACTION_W + 3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // action, x_mm, y_mm, z_mm from bit 0 up, zero padding above
  input  logic [IN_W-1:0]               s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // hit, dropped, stored_count from bit 0 up, zero padding above
  output logic [pbo_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [pbo_pkg::VOXEL_W-1:0]   cfg_wdata_i
);

  localparam int CW  = COORD_WIDTH;
  localparam int AWD = pbo_pkg::ACTION_W;
  localparam int CNW = pbo_pkg::COUNT_OUT_W;

  pbo_pkg::cmd_t cmd;
  pbo_pkg::sts_t sts;

  logic                 hit;
  logic                 dropped;
  logic [CNW-1:0]       stored_count;
  logic signed [CW-1:0] x_mm, y_mm, z_mm;

  // Unpack the input item.
  assign x_mm = s_axis_tdata[AWD +: CW];
  assign y_mm = s_axis_tdata[AWD + CW +: CW];
  assign z_mm = s_axis_tdata[AWD + 2 * CW +: CW];

  pbo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tdata[AWD-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pbo_dp #(
    .CAPACITY    (CAPACITY),
    .COORD_WIDTH (CW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .x_mm_i         (x_mm),
    .y_mm_i         (y_mm),
    .z_mm_i         (z_mm),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .hit_o          (hit),
    .dropped_o      (dropped),
    .stored_count_o (stored_count)
  );

  // Pack the result item; pad to whole bytes with zeros.
  assign m_axis_tdata = {{(pbo_pkg::OUT_W - CNW - 2){1'b0}}, stored_count, dropped, hit};

endmodule

@@ rtl/pbo_rnd.sv @@
// Rounding of one coordinate to the nearest grid multiple by reciprocal multiplication.
module pbo_rnd #(
  parameter int COORD_WIDTH = pbo_pkg::COORD_WIDTH_DEF,
  localparam int RW = COORD_WIDTH + 2
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic                          step_i,
  input  logic                          fin_i,
  input  logic signed [COORD_WIDTH-1:0] value_i,
  output logic signed [RW-1:0]          rounded_o
);

  localparam int CW = COORD_WIDTH;
  localparam int MW = CW - 2;
  localparam int PW = MW + pbo_pkg::RECIP_W;

  logic signed [CW:0]   biased;
  logic        [CW:0]   biased_abs;
  logic        [CW-1:0] mag_q, mag_d;
  logic                 neg_q, neg_d;
  logic        [PW-1:0] recip_prod;
  logic        [CW-1:0] quo_q, quo_d;
  logic        [CW-1:0] quo_x100;
  logic signed [RW-1:0] q_ext;
  logic signed [RW-1:0] q_signed_q, q_signed_d;
  logic signed [RW-1:0] prod;
  logic signed [RW-1:0] rounded_q;

  assign biased     = (CW+1)'(value_i) + (CW+1)'(pbo_pkg::ROUND_HALF);
  assign biased_abs = biased[CW] ? -biased : biased;

  always_comb begin
    mag_d = mag_q;
    neg_d = neg_q;
    if (load_i) begin
      mag_d = biased_abs[CW-1:0];
      neg_d = biased[CW];
    end
  end

  // Magnitude over 100: drop two bits, then multiply by the reciprocal of 25.
  assign recip_prod = PW'(mag_q[CW-1:2]) * PW'(pbo_pkg::RECIP_25);
  assign quo_d      = CW'(recip_prod[PW-1:pbo_pkg::RECIP_SH]);

  // Floor toward minus infinity: a negative value with a remainder steps one further.
  assign quo_x100   = (quo_q << 6) + (quo_q << 5) + (quo_q << 2);
  assign q_ext      = RW'(quo_q) + RW'(neg_q && (quo_x100 != mag_q));
  assign q_signed_d = neg_q ? -q_ext : q_ext;
  assign prod       = (q_signed_q <<< 6) + (q_signed_q <<< 5) + (q_signed_q <<< 2);

  // Two steps fill the quotient stage and then the signed quotient stage.
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    if (step_i) begin
      quo_q      <= quo_d;
      q_signed_q <= q_signed_d;
    end
    if (fin_i) begin
      rounded_q <= prod;
    end
  end

  assign rounded_o = rounded_q;

endmodule

@@ rtl/pbo_dp.sv @@
// Datapath: point store, rounding units, box test, result register.
module pbo_dp #(
  parameter int CAPACITY    = pbo_pkg::CAPACITY_DEF,
  parameter int COORD_WIDTH = pbo_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pbo_pkg::cmd_t                       cmd_i,
  output pbo_pkg::sts_t                       sts_o,
  input  logic signed [COORD_WIDTH-1:0]       x_mm_i,
  input  logic signed [COORD_WIDTH-1:0]       y_mm_i,
  input  logic signed [COORD_WIDTH-1:0]       z_mm_i,
  input  logic                                cfg_we_i,
  input  logic [pbo_pkg::VOXEL_W-1:0]         cfg_wdata_i,
  output logic                                hit_o,
  output logic                                dropped_o,
  output logic [pbo_pkg::COUNT_OUT_W-1:0]     stored_count_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int RW   = CW + 2;
  localparam int DW   = CW + 3;
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DCW  = $clog2(pbo_pkg::DIV_STEPS + 1);
  localparam int EW   = 3 * CW;

  logic [EW-1:0]   mem [CAPACITY];
  logic [EW-1:0]   rd_q;
  logic            rd_vld_q, rd_vld_d;
  logic [CNTW-1:0] count_q, count_d;
  logic [CNTW-1:0] idx_q, idx_d;
  logic [DCW-1:0]  dcnt_q, dcnt_d;
  logic            hit_q, hit_d;
  logic            drop_q, drop_d;
  logic [pbo_pkg::VOXEL_W-1:0] voxel_q;
  logic [pbo_pkg::VOXEL_W-2:0] half_voxel;
  logic            full;
  logic            wr_en, rd_en;
  logic [2:0]      axis_ok;
  logic            match;

  logic signed [CW-1:0] coord_in [3];
  logic signed [RW-1:0] rnd_val  [3];

  logic                                out_hit_q, out_drop_q;
  logic [pbo_pkg::COUNT_OUT_W-1:0]     out_count_q;
  logic [CNTW+pbo_pkg::COUNT_OUT_W-1:0] count_ext;

  assign coord_in[0] = x_mm_i;
  assign coord_in[1] = y_mm_i;
  assign coord_in[2] = z_mm_i;

  assign half_voxel = voxel_q[pbo_pkg::VOXEL_W-1:1];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [CW-1:0] stored;
    logic signed [DW-1:0] diff;
    logic        [DW-1:0] diff_abs;

    pbo_rnd #(
      .COORD_WIDTH (CW)
    ) u_rnd (
      .clk_i     (clk_i),
      .load_i    (cmd_i.accept),
      .step_i    (cmd_i.div_step),
      .fin_i     (cmd_i.round),
      .value_i   (coord_in[a]),
      .rounded_o (rnd_val[a])
    );

    // 2*|d| <= voxel is the same test as |d| <= floor(voxel/2)
    assign stored     = rd_q[a*CW +: CW];
    assign diff       = DW'(rnd_val[a]) - DW'(stored);
    assign diff_abs   = diff[DW-1] ? -diff : diff;
    assign axis_ok[a] = diff_abs <= DW'(half_voxel);
  end

  assign match = &axis_ok;
  assign full  = count_q == CNTW'(CAPACITY);
  assign wr_en = cmd_i.insert && !full;
  assign rd_en = cmd_i.scan_step && (idx_q != count_q);

  always_comb begin
    count_d  = count_q;
    idx_d    = idx_q;
    dcnt_d   = dcnt_q;
    rd_vld_d = rd_vld_q;
    hit_d    = hit_q;
    drop_d   = drop_q;
    if (cmd_i.accept) begin
      hit_d  = 1'b0;
      drop_d = 1'b0;
      dcnt_d = '0;
    end
    if (cmd_i.insert) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        count_d = count_q + CNTW'(1);
      end
    end
    if (cmd_i.clear) begin
      count_d = '0;
    end
    if (cmd_i.div_step) begin
      dcnt_d = dcnt_q + DCW'(1);
    end
    if (cmd_i.round) begin
      idx_d    = '0;
      rd_vld_d = 1'b0;
    end
    if (cmd_i.scan_step) begin
      rd_vld_d = rd_en;
      if (rd_en) begin
        idx_d = idx_q + CNTW'(1);
      end
      if (rd_vld_q && match) begin
        hit_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      dcnt_q   <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      drop_q   <= 1'b0;
      voxel_q  <= pbo_pkg::VOXEL_W'(pbo_pkg::VOXEL_RST);
    end else begin
      count_q  <= count_d;
      idx_q    <= idx_d;
      dcnt_q   <= dcnt_d;
      rd_vld_q <= rd_vld_d;
      hit_q    <= hit_d;
      drop_q   <= drop_d;
      if (cfg_we_i) begin
        voxel_q <= cfg_wdata_i;
      end
    end
  end

  // Point store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= {z_mm_i, y_mm_i, x_mm_i};
    end
    if (rd_en) begin
      rd_q <= mem[idx_q[AW-1:0]];
    end
  end

  assign count_ext = {{pbo_pkg::COUNT_OUT_W{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_hit_q   <= hit_q;
      out_drop_q  <= drop_q;
      out_count_q <= count_ext[pbo_pkg::COUNT_OUT_W-1:0];
    end
  end

  assign sts_o.div_last  = dcnt_q == DCW'(pbo_pkg::DIV_STEPS - 1);
  assign sts_o.scan_done = (idx_q == count_q) && !rd_vld_q;

  assign hit_o          = out_hit_q;
  assign dropped_o      = out_drop_q;
  assign stored_count_o = out_count_q;

endmodule

@@ rtl/pbo_ctrl.sv @@
// Controller: sequences one item at a time and owns the output valid flag.
module pbo_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pbo_pkg::ACTION_W-1:0]  action_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  pbo_pkg::sts_t                 sts_i,
  output pbo_pkg::cmd_t                 cmd_o
);

  pbo_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      pbo_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (pbo_pkg::action_e'(action_i))
            pbo_pkg::ACT_INSERT: begin
              cmd_o.insert = 1'b1;
              state_d      = pbo_pkg::ST_RESULT;
            end
            pbo_pkg::ACT_QUERY: begin
              state_d = pbo_pkg::ST_DIV;
            end
            pbo_pkg::ACT_CLEAR: begin
              cmd_o.clear = 1'b1;
              state_d     = pbo_pkg::ST_RESULT;
            end
            default: begin
              state_d = pbo_pkg::ST_RESULT;
            end
          endcase
        end
      end
      pbo_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = pbo_pkg::ST_ROUND;
        end
      end
      pbo_pkg::ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = pbo_pkg::ST_SCAN;
      end
      pbo_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = pbo_pkg::ST_RESULT;
        end
      end
      pbo_pkg::ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = pbo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pbo_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbo_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == pbo_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule
